// ===== rtl/dmxpm_pkg.sv =====
// Shared types, codes and constants of the DMX to pixel mapper.
// Used by dmxpm_ctrl, dmxpm_dp and dmx_to_pixel_mapper_core; depends on nothing.
package dmxpm_pkg;

   localparam int UNIVERSE_BYTES = 512;
   localparam int SLOT_W = 10;
   localparam int GROUP_W = 11;
   localparam int GRP_W = 7;
   // A physical pixel index can reach 2047 * 64, which needs 17 bits.
   localparam int PHYS_W = 18;

   // write_kind codes
   localparam logic [1:0] WK_RTZ3 = 2'd0;
   localparam logic [1:0] WK_RTZ4 = 2'd1;
   localparam logic [1:0] WK_WS2801 = 2'd2;
   localparam logic [1:0] WK_WORD = 2'd3;

   // pixel_kind codes
   localparam logic [1:0] PK_RTZ = 2'd0;
   localparam logic [1:0] PK_WS2801 = 2'd1;
   localparam logic [1:0] PK_APA102 = 2'd2;
   localparam logic [1:0] PK_P9813 = 2'd3;

   localparam logic [7:0] P9813_MARK = 8'hC0;

   // Register indexes
   localparam logic [2:0] REG_UNIVERSES = 3'd0;
   localparam logic [2:0] REG_CHANNELS = 3'd1;
   localparam logic [2:0] REG_GROUPING = 3'd2;
   localparam logic [2:0] REG_GROUP_COUNT = 3'd3;
   localparam logic [2:0] REG_COLOUR_ORDER = 3'd4;
   localparam logic [2:0] REG_PIXEL_KIND = 3'd5;
   localparam logic [2:0] REG_BRIGHTNESS = 3'd6;
   localparam logic [2:0] REG_BEGIN_TABLE = 3'd7;

   typedef struct packed {
      logic [4:0] port_index;
      logic       frame_start;
      logic [7:0] slot_byte;
   } req_type;

   typedef struct packed {
      logic [4:0]  output_index;
      logic [10:0] pixel_index;
      logic [1:0]  write_kind;
      logic [7:0]  byte_a;
      logic [7:0]  byte_b;
      logic [7:0]  byte_c;
      logic [7:0]  byte_d;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  universes_per_output;
      logic [2:0]  channels_per_pixel;
      logic [6:0]  grouping_count;
      logic [10:0] group_count;
      logic [2:0]  colour_order;
      logic [1:0]  pixel_kind;
      logic [7:0]  global_brightness;
      logic [47:0] begin_index_table;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      universes_per_output: 3'd1,
      channels_per_pixel:   3'd3,
      grouping_count:       7'd1,
      group_count:          11'd170,
      colour_order:         3'd0,
      pixel_kind:           PK_RTZ,
      global_brightness:    8'd255,
      begin_index_table:    48'd0
   };

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic div_step;
      logic load_frame;
      logic slot;
      logic mul;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_start;
      logic div_last;
      logic slot_over;
      logic pixel_done;
      logic group_ok;
      logic phys_ok;
      logic out_free;
      logic last_word;
   } sts_type;

   // Source positions of red, green and blue for a colour order.
   function automatic logic [5:0] order_sel(input logic [2:0] order);
      logic [5:0] sel;
      case (order)
         3'd1: sel = {2'd0, 2'd2, 2'd1};
         3'd2: sel = {2'd1, 2'd0, 2'd2};
         3'd3: sel = {2'd2, 2'd0, 2'd1};
         3'd4: sel = {2'd1, 2'd2, 2'd0};
         3'd5: sel = {2'd2, 2'd1, 2'd0};
         default: sel = {2'd0, 2'd1, 2'd2};
      endcase
      return sel;
   endfunction

   function automatic logic [7:0] pick(input logic [1:0] sel, input logic [7:0] p0,
                                       input logic [7:0] p1, input logic [7:0] p2);
      logic [7:0] v;
      case (sel)
         2'd1: v = p1;
         2'd2: v = p2;
         default: v = p0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/dmxpm_ctrl.sv =====
// Sequencing state machine of the DMX to pixel mapper.
// Uses dmxpm_pkg command and status types; drives dmxpm_dp.
module dmxpm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  dmxpm_pkg::sts_type  sts,
   output logic                req_ready,
   output dmxpm_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_SLOT = 3'd3;
   localparam logic [2:0] S_MUL  = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = req_valid ? S_SLOT : S_IDLE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load_frame = 1'b1;
            state_in = S_SLOT;
         end
         S_SLOT: begin
            cmd.slot = 1'b1;
            if (sts.slot_over || !sts.pixel_done || !sts.group_ok) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!sts.phys_ok) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.last_word) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      // A frame start first splits the port number in the divider.
      if (state_ff == S_IDLE && req_valid && sts.frame_start) begin
         state_in = S_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/dmxpm_dp.sv =====
// Datapath of the DMX to pixel mapper: divider, pixel gathering, write generation.
// Uses dmxpm_pkg; commanded by dmxpm_ctrl.
module dmxpm_dp #(
   parameter int MAX_PIXELS = 1024,
   parameter int MAX_GROUPING = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  dmxpm_pkg::cfg_type  cfg,
   input  dmxpm_pkg::req_type  req_data,
   input  dmxpm_pkg::cmd_type  cmd,
   input  logic                rsp_ready,
   output dmxpm_pkg::sts_type  sts,
   output logic                rsp_valid,
   output dmxpm_pkg::rsp_type  rsp_data
);

   localparam int PW = dmxpm_pkg::PHYS_W;
   localparam int GW = dmxpm_pkg::GRP_W;
   localparam logic [PW-1:0] MAX_PIX = PW'(MAX_PIXELS);
   localparam logic [GW-1:0] MAX_GRP = GW'(MAX_GROUPING);
   localparam logic [dmxpm_pkg::SLOT_W-1:0] SLOT_END =
      dmxpm_pkg::SLOT_W'(dmxpm_pkg::UNIVERSE_BYTES);

   dmxpm_pkg::req_type in_ff, in_in;
   logic [2:0] div_cnt_ff, div_cnt_in;
   logic [2:0] div_rem_ff, div_rem_in;
   logic [4:0] div_quo_ff, div_quo_in;
   logic [dmxpm_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [dmxpm_pkg::GROUP_W-1:0] group_ff, group_in;
   logic [7:0] pb_ff [3];
   logic [7:0] pb_in [3];
   logic [1:0] bg_ff, bg_in;
   logic [4:0] outsel_ff, outsel_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] wa_ff, wa_in, wb_ff, wb_in, wc_ff, wc_in, wd_ff, wd_in;
   logic [PW-1:0] phys_ff, phys_in;
   logic [GW-1:0] k_ff, k_in, grp_ff, grp_in;
   logic rsp_valid_ff, rsp_valid_in;
   dmxpm_pkg::rsp_type rsp_ff, rsp_in;

   logic [2:0] u_eff;
   logic [3:0] r4;
   logic ge;
   logic [11:0] begin_idx;
   logic [2:0] cpp;
   logic pixel_done;
   logic [5:0] sel;
   logic [7:0] red, grn, blu;
   logic [GW-1:0] grp;
   logic [PW-1:0] phys_plus;
   logic [PW-1:0] pix_index;
   logic last_word;

   always_comb begin
      u_eff = (cfg.universes_per_output == 3'd0) ? 3'd1 : cfg.universes_per_output;
      r4 = {div_rem_ff, in_ff.port_index[div_cnt_ff]};
      ge = r4 >= {1'b0, u_eff};
      case (div_rem_ff[1:0])
         2'd1: begin_idx = cfg.begin_index_table[23:12];
         2'd2: begin_idx = cfg.begin_index_table[35:24];
         2'd3: begin_idx = cfg.begin_index_table[47:36];
         default: begin_idx = cfg.begin_index_table[11:0];
      endcase
      cpp = (cfg.channels_per_pixel == 3'd4) ? 3'd4 : 3'd3;
      pixel_done = !((3'({1'b0, bg_ff}) + 3'd1) < cpp);
      sel = dmxpm_pkg::order_sel(cfg.colour_order);
      red = dmxpm_pkg::pick(sel[5:4], pb_ff[0], pb_ff[1], in_ff.slot_byte);
      grn = dmxpm_pkg::pick(sel[3:2], pb_ff[0], pb_ff[1], in_ff.slot_byte);
      blu = dmxpm_pkg::pick(sel[1:0], pb_ff[0], pb_ff[1], in_ff.slot_byte);
      grp = (cfg.grouping_count == 7'd0) ? 7'd1 : cfg.grouping_count;
      if (grp > MAX_GRP) begin
         grp = MAX_GRP;
      end
      phys_plus = phys_ff + PW'(1);
      pix_index = (kind_ff == dmxpm_pkg::WK_WORD) ? phys_plus : phys_ff;
      last_word = (k_ff == grp_ff - GW'(1)) || (phys_plus >= MAX_PIX);
   end

   always_comb begin
      in_in = in_ff;
      div_cnt_in = div_cnt_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      slot_in = slot_ff;
      group_in = group_ff;
      pb_in = pb_ff;
      bg_in = bg_ff;
      outsel_in = outsel_ff;
      kind_in = kind_ff;
      wa_in = wa_ff;
      wb_in = wb_ff;
      wc_in = wc_ff;
      wd_in = wd_ff;
      phys_in = phys_ff;
      k_in = k_ff;
      grp_in = grp_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.capture) begin
         in_in = req_data;
         div_cnt_in = 3'd4;
         div_rem_in = 3'd0;
         div_quo_in = 5'd0;
      end

      // Restoring division, one quotient bit per step, most significant first.
      if (cmd.div_step) begin
         div_rem_in = ge ? 3'(r4 - {1'b0, u_eff}) : r4[2:0];
         div_quo_in[div_cnt_ff] = ge;
         div_cnt_in = div_cnt_ff - 3'd1;
      end

      if (cmd.load_frame) begin
         outsel_in = div_quo_ff;
         group_in = (begin_idx < {1'b0, cfg.group_count}) ? begin_idx[10:0]
                                                          : cfg.group_count;
         slot_in = '0;
         bg_in = 2'd0;
         pb_in = '{default: 8'd0};
      end

      if (cmd.slot && (slot_ff < SLOT_END)) begin
         slot_in = slot_ff + dmxpm_pkg::SLOT_W'(1);
         if (!pixel_done) begin
            pb_in[bg_ff] = in_ff.slot_byte;
            bg_in = bg_ff + 2'd1;
         end else begin
            pb_in = '{default: 8'd0};
            bg_in = 2'd0;
            if (cpp == 3'd4) begin
               kind_in = dmxpm_pkg::WK_RTZ4;
               wa_in = pb_ff[0];
               wb_in = pb_ff[1];
               wc_in = pb_ff[2];
               wd_in = in_ff.slot_byte;
            end else begin
               case (cfg.pixel_kind)
                  dmxpm_pkg::PK_RTZ, dmxpm_pkg::PK_WS2801: begin
                     kind_in = (cfg.pixel_kind == dmxpm_pkg::PK_RTZ) ?
                               dmxpm_pkg::WK_RTZ3 : dmxpm_pkg::WK_WS2801;
                     wa_in = red;
                     wb_in = grn;
                     wc_in = blu;
                     wd_in = 8'd0;
                  end
                  default: begin
                     kind_in = dmxpm_pkg::WK_WORD;
                     wb_in = blu;
                     wc_in = grn;
                     wd_in = red;
                     if (cfg.pixel_kind == dmxpm_pkg::PK_APA102) begin
                        wa_in = cfg.global_brightness;
                     end else begin
                        wa_in = dmxpm_pkg::P9813_MARK |
                                {2'b00, ~blu[7:6], ~grn[7:6], ~red[7:6]};
                     end
                  end
               endcase
            end
         end
      end

      if (cmd.mul) begin
         phys_in = PW'(group_ff) * PW'(grp);
         grp_in = grp;
         k_in = '0;
         group_in = group_ff + dmxpm_pkg::GROUP_W'(1);
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_in.output_index = outsel_ff;
         rsp_in.pixel_index = pix_index[10:0];
         rsp_in.write_kind = kind_ff;
         rsp_in.byte_a = wa_ff;
         rsp_in.byte_b = wb_ff;
         rsp_in.byte_c = wc_ff;
         rsp_in.byte_d = wd_ff;
         rsp_in.last_of_run = last_word;
         phys_in = phys_plus;
         k_in = k_ff + GW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         group_ff <= '0;
         pb_ff <= '{default: 8'd0};
         bg_ff <= 2'd0;
         outsel_ff <= 5'd0;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff <= 3'd0;
      end else begin
         slot_ff <= slot_in;
         group_ff <= group_in;
         pb_ff <= pb_in;
         bg_ff <= bg_in;
         outsel_ff <= outsel_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      kind_ff <= kind_in;
      wa_ff <= wa_in;
      wb_ff <= wb_in;
      wc_ff <= wc_in;
      wd_ff <= wd_in;
      phys_ff <= phys_in;
      k_ff <= k_in;
      grp_ff <= grp_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      sts.frame_start = req_data.frame_start;
      sts.div_last = (div_cnt_ff == 3'd0);
      sts.slot_over = (slot_ff >= SLOT_END);
      sts.pixel_done = pixel_done;
      sts.group_ok = (group_ff < cfg.group_count);
      sts.phys_ok = (phys_ff < MAX_PIX);
      sts.out_free = !rsp_valid_ff || rsp_ready;
      sts.last_word = last_word;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/dmx_to_pixel_mapper_core.sv =====
// Top level of the DMX to pixel mapper: register file, controller and datapath.
// Depends on dmxpm_pkg, dmxpm_ctrl and dmxpm_dp.
//
// Usage: DMX slot words enter on the req_ channel (valid/ready), each tagged with
// its port number and a frame-start mark. Pixel write words leave on the rsp_
// channel (valid/ready); the last write of each grouping run carries last_of_run.
// Configuration registers sit on an APB-style port at byte address 8*i, 64-bit
// data; writes are meant to happen only while the block is idle.
// Timing: the block works on one input word at a time. A word that does not
// finish a pixel passes through capture and the slot step. A frame-start word
// first goes through the five-step restoring divider that splits the port and a
// load step. A word that finishes a pixel then goes through a multiply step and
// issues its writes one after another.
// Results go through an output register: a new input word is accepted while the
// last write still waits there. When the receiver stalls, write generation
// waits on that register and input acceptance stops until the run is out.
// Reset returns all configuration registers to their defaults and clears the frame state.
module dmx_to_pixel_mapper_core #(
   parameter int MAX_PIXELS = 1024,
   parameter int MAX_GROUPING = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  dmxpm_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dmxpm_pkg::rsp_type  rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [5:0]          paddr,
   input  logic [63:0]         pwdata,
   output logic [63:0]         prdata,
   output logic                pready
);

   dmxpm_pkg::cfg_type cfg_ff;
   dmxpm_pkg::cfg_type cfg_in;
   dmxpm_pkg::cmd_type cmd;
   dmxpm_pkg::sts_type sts;
   logic cfg_write;

   assign pready = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   // Register writes; only the low bits of each register are kept.
   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (paddr[5:3])
            dmxpm_pkg::REG_UNIVERSES:    cfg_in.universes_per_output = pwdata[2:0];
            dmxpm_pkg::REG_CHANNELS:     cfg_in.channels_per_pixel = pwdata[2:0];
            dmxpm_pkg::REG_GROUPING:     cfg_in.grouping_count = pwdata[6:0];
            dmxpm_pkg::REG_GROUP_COUNT:  cfg_in.group_count = pwdata[10:0];
            dmxpm_pkg::REG_COLOUR_ORDER: cfg_in.colour_order = pwdata[2:0];
            dmxpm_pkg::REG_PIXEL_KIND:   cfg_in.pixel_kind = pwdata[1:0];
            dmxpm_pkg::REG_BRIGHTNESS:   cfg_in.global_brightness = pwdata[7:0];
            dmxpm_pkg::REG_BEGIN_TABLE:  cfg_in.begin_index_table = pwdata[47:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= dmxpm_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back of the register that paddr selects.
   always_comb begin
      case (paddr[5:3])
         dmxpm_pkg::REG_UNIVERSES:    prdata = 64'(cfg_ff.universes_per_output);
         dmxpm_pkg::REG_CHANNELS:     prdata = 64'(cfg_ff.channels_per_pixel);
         dmxpm_pkg::REG_GROUPING:     prdata = 64'(cfg_ff.grouping_count);
         dmxpm_pkg::REG_GROUP_COUNT:  prdata = 64'(cfg_ff.group_count);
         dmxpm_pkg::REG_COLOUR_ORDER: prdata = 64'(cfg_ff.colour_order);
         dmxpm_pkg::REG_PIXEL_KIND:   prdata = 64'(cfg_ff.pixel_kind);
         dmxpm_pkg::REG_BRIGHTNESS:   prdata = 64'(cfg_ff.global_brightness);
         dmxpm_pkg::REG_BEGIN_TABLE:  prdata = 64'(cfg_ff.begin_index_table);
         default: prdata = 64'd0;
      endcase
   end

   dmxpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   dmxpm_dp #(
      .MAX_PIXELS   (MAX_PIXELS),
      .MAX_GROUPING (MAX_GROUPING)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // A write is only generated into a free output register and below the pixel limit.
   a_emit_safe: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (sts.out_free && sts.phys_ok))
      else $error("write generated into a busy output register or past the limit");

   // The controller issues at most one command per cycle.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.div_step, cmd.load_frame, cmd.slot, cmd.mul, cmd.emit}))
      else $error("more than one datapath command in a cycle");

   // An accepted word is processed before the next one is taken.
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input word accepted in back-to-back cycles");
`endif

endmodule
